### sv/cbpe_pkg.sv
// Package for the circular bit packer: op codes, sequencer states, control group.
package cbpe_pkg;

  // Op codes of the input channel
  localparam logic [1:0] OP_BITS = 2'd0;
  localparam logic [1:0] OP_ESC  = 2'd1;
  localparam logic [1:0] OP_RST  = 2'd2;

  // Field widths and limits fixed by the interface
  localparam int unsigned MAX_WIDTH  = 32;
  localparam int unsigned CFG_W      = 13;
  localparam logic [CFG_W-1:0] CFG_SIZE_RST = 13'd4096;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CALC,
    S_SUM,
    S_LOAD,
    S_RD,
    S_MRG,
    S_EMPTY
  } state_t;

  // Control group from the output decode to the datapath
  typedef struct packed {
    logic mem_rd;
    logic mem_we;
    logic out_ld;
    logic out_byte;
    logic last;
  } ctl_t;

endpackage

### sv/circular_bit_packer_escape_writer.sv
// Circular MSB-first bit packer with escaped-value writer, store held in one RAM.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | op, value, width1, width2, width3
//  out      | out_valid / out_stall | byte_valid, byte_address, byte_value,
//           |                       | item_bits, bit_total, last
//  cfg      | cfg_valid / cfg_ready | buffer_size_bytes (cfg_data)
//
// After reset a clearing pass zeroes the store, with in_stall high.
// Op 0/1: accept, three escape-field steps, a total step, and a load step per field
// up to the last field that carries bits, then per byte touched a RAM read, then
// merge and write back. Op 2/3 and zero-width items end in a single result with no byte.
// The single-port byte RAM sets the byte rate.
// A stalled result holds in the output register; the block stalls at the next byte.
module circular_bit_packer_escape_writer #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [31:0]                    in_value,
  input  logic [5:0]                     in_width1,
  input  logic [5:0]                     in_width2,
  input  logic [5:0]                     in_width3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_byte_valid,
  output logic [11:0]                    out_byte_address,
  output logic [7:0]                     out_byte_value,
  output logic [6:0]                     out_item_bits,
  output logic [31:0]                    out_bit_total,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbpe_pkg::CFG_W-1:0]     cfg_data
);
  import cbpe_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned SW = $clog2(STORE_BYTES + 1);

  // Byte store
  logic [7:0]     mem [STORE_BYTES];
  logic [7:0]     rdata_r;

  // Control and item state
  state_t         state_r, state_nxt;
  ctl_t           ctl;
  logic [AW-1:0]  clr_cnt_r;
  logic [CFG_W-1:0] size_r;
  logic [AW-1:0]  idx_r;
  logic [2:0]     pos_r;
  logic [31:0]    total_r;
  logic [1:0]     op_r;
  logic [31:0]    v_r;
  logic [5:0]     w_r [3];
  logic [31:0]    e_r [3];
  logic [2:0]     use_r;
  logic           go_r;
  logic [1:0]     fld_r;
  logic [6:0]     bits_r;
  logic [31:0]    fv_r;
  logic [5:0]     rem_r;

  // Output register
  logic           out_valid_r;
  logic           out_bv_r;
  logic [11:0]    out_addr_r;
  logic [7:0]     out_val_r;
  logic [6:0]     out_bits_r;
  logic [31:0]    out_total_r;
  logic           out_last_r;

  logic           in_acc;
  logic           out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Width saturation at 32
  function automatic logic [5:0] clamp_w(input logic [5:0] w);
    return (w > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : w;
  endfunction

  // Effective store size, saturated to [1, STORE_BYTES]
  logic [SW-1:0] eff_size;
  always_comb begin
    if (size_r == '0) begin
      eff_size = SW'(1);
    end else if (32'(size_r) > STORE_BYTES) begin
      eff_size = SW'(STORE_BYTES);
    end else begin
      eff_size = SW'(size_r);
    end
  end

  // Escape field: for op 1 saturate the remaining value at the field maximum
  logic [5:0]  calc_w;
  logic [31:0] calc_m;
  logic [31:0] calc_e;
  always_comb begin
    case (fld_r)
      2'd1:    calc_w = w_r[1];
      2'd2:    calc_w = w_r[2];
      default: calc_w = w_r[0];
    endcase
    calc_m = calc_w[5] ? 32'hFFFF_FFFF : ((32'd1 << calc_w[4:0]) - 32'd1);
    if (op_r == OP_ESC) begin
      calc_e = (v_r < calc_m) ? v_r : calc_m;
    end else begin
      calc_e = v_r;
    end
  end

  // Fields that carry bits, and the one selected by fld_r
  logic [2:0]  ne;
  logic        cur_ne;
  logic        later_ne;
  logic [31:0] cur_e;
  logic [5:0]  cur_w;
  always_comb begin
    for (int f = 0; f < 3; f++) begin
      ne[f] = use_r[f] && (w_r[f] != 6'd0);
    end
    case (fld_r)
      2'd1: begin
        cur_ne = ne[1]; later_ne = ne[2]; cur_e = e_r[1]; cur_w = w_r[1];
      end
      2'd2: begin
        cur_ne = ne[2]; later_ne = 1'b0; cur_e = e_r[2]; cur_w = w_r[2];
      end
      default: begin
        cur_ne = ne[0]; later_ne = ne[1] | ne[2]; cur_e = e_r[0]; cur_w = w_r[0];
      end
    endcase
  end

  // Chunk of the current byte: k bits at bit position pos_r downward
  logic [3:0]  room;
  logic [3:0]  k;
  logic [3:0]  sh;
  logic [7:0]  kmask;
  logic [7:0]  msk;
  logic [7:0]  chunk;
  logic [7:0]  new_byte;
  logic [5:0]  rem_after;
  logic        idx_wrap;
  always_comb begin
    room      = {1'b0, pos_r} + 4'd1;
    k         = (rem_r < {2'b00, room}) ? rem_r[3:0] : room;
    sh        = room - k;
    kmask     = 8'((9'd1 << k) - 9'd1);
    msk       = 8'(kmask << sh);
    chunk     = fv_r[31:24] >> (3'd7 - pos_r);
    new_byte  = (rdata_r & ~msk) | (chunk & msk);
    rem_after = rem_r - {2'b00, k};
    idx_wrap  = (32'(idx_r) + 32'd1) >= 32'(eff_size);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_cnt_r == AW'(STORE_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_op inside {OP_BITS, OP_ESC}) state_nxt = S_CALC;
          else                                state_nxt = S_EMPTY;
        end
      end
      S_CALC: begin
        if (fld_r == 2'd2) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = (ne != 3'b000) ? S_LOAD : S_EMPTY;
      end
      S_LOAD: begin
        if (cur_ne) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_MRG;
      end
      S_MRG: begin
        if (out_free) begin
          if (rem_after != 6'd0) state_nxt = S_RD;
          else if (later_ne)     state_nxt = S_LOAD;
          else                   state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    ctl = '0;
    case (state_r)
      S_CLR: begin
        ctl.mem_we = 1'b1;
      end
      S_RD: begin
        ctl.mem_rd = 1'b1;
      end
      S_MRG: begin
        ctl.mem_we   = out_free;
        ctl.out_ld   = out_free;
        ctl.out_byte = 1'b1;
        ctl.last     = (rem_after == 6'd0) && !later_ne;
      end
      S_EMPTY: begin
        ctl.out_ld = out_free;
        ctl.last   = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  // Store RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      if (state_r == S_CLR) mem[clr_cnt_r] <= 8'd0;
      else                  mem[idx_r]     <= new_byte;
    end
    if (ctl.mem_rd) rdata_r <= mem[idx_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      size_r      <= CFG_SIZE_RST;
      idx_r       <= '0;
      pos_r       <= 3'd7;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (in_acc && (in_op == OP_RST)) begin
        idx_r   <= '0;
        pos_r   <= 3'd7;
        total_r <= '0;
      end
      if (state_r == S_SUM) total_r <= total_r + 32'(bits_r);
      // Pointer step after each byte merge
      if (state_r == S_MRG && out_free) begin
        if (k == room) begin
          pos_r <= 3'd7;
          idx_r <= idx_wrap ? '0 : idx_r + AW'(1);
        end else begin
          pos_r <= pos_r - k[2:0];
        end
      end
      if (ctl.out_ld)              out_valid_r <= 1'b1;
      else if (!out_stall)         out_valid_r <= 1'b0;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      v_r    <= in_value;
      w_r[0] <= clamp_w(in_width1);
      w_r[1] <= clamp_w(in_width2);
      w_r[2] <= clamp_w(in_width3);
      use_r  <= 3'b000;
      go_r   <= 1'b1;
      fld_r  <= 2'd0;
      bits_r <= 7'd0;
    end
    // One escape field per cycle
    if (state_r == S_CALC) begin
      if (go_r) begin
        e_r[fld_r]   <= calc_e;
        use_r[fld_r] <= 1'b1;
        bits_r       <= bits_r + 7'(calc_w);
        v_r          <= v_r - calc_e;
        go_r         <= (op_r == OP_ESC) && (calc_e == calc_m);
      end
      fld_r <= (fld_r == 2'd2) ? 2'd0 : fld_r + 2'd1;
    end
    // Field load: top-align the field bits
    if (state_r == S_LOAD) begin
      if (cur_ne) begin
        fv_r  <= cur_e << (6'd32 - cur_w);
        rem_r <= cur_w;
      end else begin
        fld_r <= fld_r + 2'd1;
      end
    end
    if (state_r == S_MRG && out_free) begin
      fv_r  <= fv_r << k;
      rem_r <= rem_after;
      if (rem_after == 6'd0) fld_r <= fld_r + 2'd1;
    end
  end

  // Output payload register
  logic [31:0] idx_ext;
  assign idx_ext = 32'(idx_r);
  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_bv_r    <= ctl.out_byte;
      out_addr_r  <= ctl.out_byte ? idx_ext[11:0] : 12'd0;
      out_val_r   <= ctl.out_byte ? new_byte : 8'd0;
      out_bits_r  <= ctl.last ? bits_r : 7'd0;
      out_total_r <= total_r;
      out_last_r  <= ctl.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = out_bv_r;
  assign out_byte_address = out_addr_r;
  assign out_byte_value   = out_val_r;
  assign out_item_bits    = out_bits_r;
  assign out_bit_total    = out_total_r;
  assign out_last         = out_last_r;

  // Assertions
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mem_we |-> (state_r == S_MRG || state_r == S_CLR))
    else $error("store written outside merge or clear");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRG) |-> (k != 4'd0 && rem_r <= 6'(MAX_WIDTH)))
    else $error("byte merge with no bits left");

  a_not_last_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_ld && !ctl.last) |=> (state_r != S_IDLE))
    else $error("item ended before its last result");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR && state_r != S_IDLE) |-> (bits_r <= 7'd96))
    else $error("item bit count above three full fields");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("input accepted during clearing pass");

endmodule
